### hw/rtl/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg
// shared codes, widths and stage control type of the complex integer alu
// ----------------------------------------------------------------------------
`default_nettype none

package cia_pkg;

   localparam int OPERAND_WIDTH_DEF = 16;
   localparam int RES_WIDTH         = 33;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // control that travels with every item down the pipeline
   typedef struct packed {
      logic       valid;
      logic [1:0] op;
      logic       dz;
      logic       neg_re;
      logic       neg_im;
   } ctl_type;

endpackage

`default_nettype wire

### hw/rtl/cia_front.sv
// ----------------------------------------------------------------------------
// cia_front
// input register, product stage and combine stage of the complex alu
// ----------------------------------------------------------------------------
`default_nettype none

module cia_front #(
   parameter int W = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic                        req_valid,
   input  wire logic [1:0]                  req_op,
   input  wire logic [W-1:0]                a_re,
   input  wire logic [W-1:0]                a_im,
   input  wire logic [W-1:0]                b_re,
   input  wire logic [W-1:0]                b_im,
   output      cia_pkg::ctl_type            ctl_out,
   output      logic [2*W-1:0]              den_out,
   output      logic [2*W-1:0]              num_re_out,
   output      logic [2*W-1:0]              num_im_out,
   output      logic [cia_pkg::RES_WIDTH-1:0] pass_re_out,
   output      logic [cia_pkg::RES_WIDTH-1:0] pass_im_out
);
   import cia_pkg::*;

   localparam int MW = 2 * W;
   localparam int SW = (MW + 2 > RES_WIDTH) ? MW + 2 : RES_WIDTH;

   // stage 1: operands
   logic              v1_ff;
   logic [1:0]        op1_ff;
   logic signed [W-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff <= req_op;
         ar1_ff <= a_re;
         ai1_ff <= a_im;
         br1_ff <= b_re;
         bi1_ff <= b_im;
      end
   end

   // stage 2: products and add / subtract
   logic signed [SW-1:0] ar1_x, ai1_x, br1_x, bi1_x;
   logic signed [SW-1:0] as_re_in, as_im_in;

   assign ar1_x = {{(SW-W){ar1_ff[W-1]}}, ar1_ff};
   assign ai1_x = {{(SW-W){ai1_ff[W-1]}}, ai1_ff};
   assign br1_x = {{(SW-W){br1_ff[W-1]}}, br1_ff};
   assign bi1_x = {{(SW-W){bi1_ff[W-1]}}, bi1_ff};

   always_comb begin
      if (op1_ff == OP_SUB) begin
         as_re_in = ar1_x - br1_x;
         as_im_in = ai1_x - bi1_x;
      end else begin
         as_re_in = ar1_x + br1_x;
         as_im_in = ai1_x + bi1_x;
      end
   end

   logic                 v2_ff;
   logic [1:0]           op2_ff;
   logic signed [MW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_ff, p_cc_ff;
   logic [RES_WIDTH-1:0] as_re_ff, as_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op2_ff   <= op1_ff;
         p_rr_ff  <= ar1_ff * br1_ff;
         p_ii_ff  <= ai1_ff * bi1_ff;
         p_ri_ff  <= ar1_ff * bi1_ff;
         p_ir_ff  <= ai1_ff * br1_ff;
         p_bb_ff  <= br1_ff * br1_ff;
         p_cc_ff  <= bi1_ff * bi1_ff;
         as_re_ff <= as_re_in[RES_WIDTH-1:0];
         as_im_ff <= as_im_in[RES_WIDTH-1:0];
      end
   end

   // stage 3: combine products, divide numerators as sign and magnitude
   logic signed [SW-1:0] rr_x, ii_x, ri_x, ir_x;
   logic signed [SW-1:0] mul_re, mul_im, dnum_re, dnum_im;
   logic [SW-1:0]        mag_re, mag_im;
   logic [MW-1:0]        den_in;
   ctl_type              ctl_in;
   logic [RES_WIDTH-1:0] pass_re_in, pass_im_in;

   assign rr_x = {{(SW-MW){p_rr_ff[MW-1]}}, p_rr_ff};
   assign ii_x = {{(SW-MW){p_ii_ff[MW-1]}}, p_ii_ff};
   assign ri_x = {{(SW-MW){p_ri_ff[MW-1]}}, p_ri_ff};
   assign ir_x = {{(SW-MW){p_ir_ff[MW-1]}}, p_ir_ff};

   assign mul_re  = rr_x - ii_x;
   assign mul_im  = ri_x + ir_x;
   assign dnum_re = rr_x + ii_x;
   assign dnum_im = ir_x - ri_x;
   assign mag_re  = dnum_re[SW-1] ? (-dnum_re) : dnum_re;
   assign mag_im  = dnum_im[SW-1] ? (-dnum_im) : dnum_im;
   // both squares are non-negative and their sum fits the magnitude width
   assign den_in  = p_bb_ff + p_cc_ff;

   always_comb begin
      ctl_in.valid  = v2_ff;
      ctl_in.op     = op2_ff;
      ctl_in.dz     = (op2_ff == OP_DIV) && (den_in == '0);
      ctl_in.neg_re = dnum_re[SW-1];
      ctl_in.neg_im = dnum_im[SW-1];
      if (op2_ff == OP_MUL) begin
         pass_re_in = mul_re[RES_WIDTH-1:0];
         pass_im_in = mul_im[RES_WIDTH-1:0];
      end else begin
         pass_re_in = as_re_ff;
         pass_im_in = as_im_ff;
      end
   end

   ctl_type              ctl3_ff;
   logic [MW-1:0]        den3_ff, num_re3_ff, num_im3_ff;
   logic [RES_WIDTH-1:0] pass_re3_ff, pass_im3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
      end else if (en) begin
         ctl3_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den3_ff     <= den_in;
         num_re3_ff  <= mag_re[MW-1:0];
         num_im3_ff  <= mag_im[MW-1:0];
         pass_re3_ff <= pass_re_in;
         pass_im3_ff <= pass_im_in;
      end
   end

   assign ctl_out     = ctl3_ff;
   assign den_out     = den3_ff;
   assign num_re_out  = num_re3_ff;
   assign num_im_out  = num_im3_ff;
   assign pass_re_out = pass_re3_ff;
   assign pass_im_out = pass_im3_ff;

endmodule

`default_nettype wire

### hw/rtl/cia_div_stage.sv
// ----------------------------------------------------------------------------
// cia_div_stage
// one restoring division step for the real and imaginary lanes
// ----------------------------------------------------------------------------
`default_nettype none

module cia_div_stage #(
   parameter int MW = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire cia_pkg::ctl_type              ctl_up,
   input  wire logic [MW-1:0]                 den_up,
   input  wire logic [MW-1:0]                 rem_re_up,
   input  wire logic [MW-1:0]                 rem_im_up,
   input  wire logic [MW-1:0]                 nq_re_up,
   input  wire logic [MW-1:0]                 nq_im_up,
   input  wire logic [cia_pkg::RES_WIDTH-1:0] pass_re_up,
   input  wire logic [cia_pkg::RES_WIDTH-1:0] pass_im_up,
   output      cia_pkg::ctl_type              ctl_dn,
   output      logic [MW-1:0]                 den_dn,
   output      logic [MW-1:0]                 rem_re_dn,
   output      logic [MW-1:0]                 rem_im_dn,
   output      logic [MW-1:0]                 nq_re_dn,
   output      logic [MW-1:0]                 nq_im_dn,
   output      logic [cia_pkg::RES_WIDTH-1:0] pass_re_dn,
   output      logic [cia_pkg::RES_WIDTH-1:0] pass_im_dn
);
   import cia_pkg::*;

   // nq holds the unused dividend bits on top and the quotient bits below
   logic [MW:0]   t_re, t_im, d_re, d_im;
   logic          ge_re, ge_im;
   logic [MW-1:0] rem_re_in, rem_im_in, nq_re_in, nq_im_in;

   assign t_re  = {rem_re_up, nq_re_up[MW-1]};
   assign t_im  = {rem_im_up, nq_im_up[MW-1]};
   assign d_re  = t_re - {1'b0, den_up};
   assign d_im  = t_im - {1'b0, den_up};
   assign ge_re = t_re >= {1'b0, den_up};
   assign ge_im = t_im >= {1'b0, den_up};

   assign rem_re_in = ge_re ? d_re[MW-1:0] : t_re[MW-1:0];
   assign rem_im_in = ge_im ? d_im[MW-1:0] : t_im[MW-1:0];
   assign nq_re_in  = {nq_re_up[MW-2:0], ge_re};
   assign nq_im_in  = {nq_im_up[MW-2:0], ge_im};

   ctl_type              ctl_ff;
   logic [MW-1:0]        den_ff, rem_re_ff, rem_im_ff, nq_re_ff, nq_im_ff;
   logic [RES_WIDTH-1:0] pass_re_ff, pass_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_up;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff     <= den_up;
         rem_re_ff  <= rem_re_in;
         rem_im_ff  <= rem_im_in;
         nq_re_ff   <= nq_re_in;
         nq_im_ff   <= nq_im_in;
         pass_re_ff <= pass_re_up;
         pass_im_ff <= pass_im_up;
      end
   end

   assign ctl_dn     = ctl_ff;
   assign den_dn     = den_ff;
   assign rem_re_dn  = rem_re_ff;
   assign rem_im_dn  = rem_im_ff;
   assign nq_re_dn   = nq_re_ff;
   assign nq_im_dn   = nq_im_ff;
   assign pass_re_dn = pass_re_ff;
   assign pass_im_dn = pass_im_ff;

endmodule

`default_nettype wire

### hw/rtl/complex_integer_alu.sv
// path from input accept to result: operand, product and combine stages, the divide stages, then the output register
// throughput: one item per cycle while every result is taken, set by the fully pipelined multiply and divide stages
// the divide takes one quotient bit per stage over 2*OPERAND_WIDTH stages
// a stall on the result side freezes the whole pipeline, nothing is lost or repeated
// reset: synchronous, active high, clears all valid bits and the stage control words; no other state
// ----------------------------------------------------------------------------
// complex_integer_alu
// signed complex add, subtract, multiply and truncating divide on a stream
// ----------------------------------------------------------------------------
`default_nettype none

module complex_integer_alu #(
   parameter int OPERAND_WIDTH = cia_pkg::OPERAND_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input item
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // a_re, a_im, b_re, b_im from the lowest bit up, zero padded to bytes
   input  wire logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] req_tdata,
   // req_type
   input  wire logic [1:0]                          req_tuser,
   // result item
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // res_re, res_im from the lowest bit up, zero padded to bytes
   output      logic [((2*cia_pkg::RES_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // div_by_zero
   output      logic [0:0]                          rsp_tuser
);
   import cia_pkg::*;

   localparam int W   = OPERAND_WIDTH;
   localparam int MW  = 2 * W;
   localparam int XW  = (MW > RES_WIDTH) ? MW : RES_WIDTH;
   localparam int IDW = ((4*W+7)/8)*8;
   localparam int ODW = ((2*RES_WIDTH+7)/8)*8;

   // whole pipeline advances unless a result is waiting and not taken
   logic en;
   logic out_valid_ff;

   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   // front: operand, product and combine stages
   ctl_type              ctl_w    [0:MW];
   logic [MW-1:0]        den_w    [0:MW];
   logic [MW-1:0]        rem_re_w [0:MW];
   logic [MW-1:0]        rem_im_w [0:MW];
   logic [MW-1:0]        nq_re_w  [0:MW];
   logic [MW-1:0]        nq_im_w  [0:MW];
   logic [RES_WIDTH-1:0] pass_re_w[0:MW];
   logic [RES_WIDTH-1:0] pass_im_w[0:MW];

   cia_front #(
      .W (W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .req_valid   (req_tvalid),
      .req_op      (req_tuser),
      .a_re        (req_tdata[W-1:0]),
      .a_im        (req_tdata[2*W-1:W]),
      .b_re        (req_tdata[3*W-1:2*W]),
      .b_im        (req_tdata[4*W-1:3*W]),
      .ctl_out     (ctl_w[0]),
      .den_out     (den_w[0]),
      .num_re_out  (nq_re_w[0]),
      .num_im_out  (nq_im_w[0]),
      .pass_re_out (pass_re_w[0]),
      .pass_im_out (pass_im_w[0])
   );

   // partial remainders start at zero
   assign rem_re_w[0] = '0;
   assign rem_im_w[0] = '0;

   // divider: one quotient bit per stage, every item passes through
   for (genvar k = 0; k < MW; k++) begin : g_div
      cia_div_stage #(
         .MW (MW)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .ctl_up     (ctl_w[k]),
         .den_up     (den_w[k]),
         .rem_re_up  (rem_re_w[k]),
         .rem_im_up  (rem_im_w[k]),
         .nq_re_up   (nq_re_w[k]),
         .nq_im_up   (nq_im_w[k]),
         .pass_re_up (pass_re_w[k]),
         .pass_im_up (pass_im_w[k]),
         .ctl_dn     (ctl_w[k+1]),
         .den_dn     (den_w[k+1]),
         .rem_re_dn  (rem_re_w[k+1]),
         .rem_im_dn  (rem_im_w[k+1]),
         .nq_re_dn   (nq_re_w[k+1]),
         .nq_im_dn   (nq_im_w[k+1]),
         .pass_re_dn (pass_re_w[k+1]),
         .pass_im_dn (pass_im_w[k+1])
      );
   end

   // final stage: apply quotient signs and pick the result by operation
   ctl_type              ctl_end;
   logic [XW-1:0]        q_re_x, q_im_x, sq_re_x, sq_im_x;
   logic [RES_WIDTH-1:0] res_re_in, res_im_in;
   logic                 dz_in;

   assign ctl_end = ctl_w[MW];
   assign q_re_x  = {{(XW-MW){1'b0}}, nq_re_w[MW]};
   assign q_im_x  = {{(XW-MW){1'b0}}, nq_im_w[MW]};
   // truncation toward zero: divide magnitudes, then restore the sign
   assign sq_re_x = ctl_end.neg_re ? (-q_re_x) : q_re_x;
   assign sq_im_x = ctl_end.neg_im ? (-q_im_x) : q_im_x;

   always_comb begin
      dz_in = ctl_end.dz;
      if (ctl_end.op == OP_DIV) begin
         if (ctl_end.dz) begin
            // zero divisor: zero results with the flag raised
            res_re_in = '0;
            res_im_in = '0;
         end else begin
            res_re_in = sq_re_x[RES_WIDTH-1:0];
            res_im_in = sq_im_x[RES_WIDTH-1:0];
         end
      end else begin
         res_re_in = pass_re_w[MW];
         res_im_in = pass_im_w[MW];
      end
   end

   // output register
   logic [RES_WIDTH-1:0] res_re_ff, res_im_ff;
   logic                 dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= ctl_end.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         dz_ff     <= dz_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(ODW-2*RES_WIDTH){1'b0}}, res_im_ff, res_re_ff};
   assign rsp_tuser  = dz_ff;

   // padding bits of the input item are not used
   if (IDW > 4*W) begin : g_pad
      logic unused_pad;
      assign unused_pad = ^req_tdata[IDW-1:4*W];
   end

endmodule

`default_nettype wire

### sim/tb_complex_integer_alu.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_complex_integer_alu
// drives complex operand pairs with random gaps and result-side stalls,
// predicts each sum, difference, product and truncated quotient and compares
// every result item in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_complex_integer_alu;
   import cia_pkg::*;

   localparam int OW = OPERAND_WIDTH_DEF;
   localparam int DW = ((4*OW+7)/8)*8;
   localparam int RW = ((2*RES_WIDTH+7)/8)*8;
   localparam int PIPE_DEPTH = 2*OW + 4;

   typedef struct {
      logic [RES_WIDTH-1:0] re;
      logic [RES_WIDTH-1:0] im;
      logic                 dz;
   } cplx_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   // a_re, a_im, b_re, b_im from the lowest bit up
   logic [DW-1:0] req_tdata = '0;
   // req_type
   logic [1:0]    req_tuser = OP_ADD;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   // res_re, res_im from the lowest bit up
   logic [RW-1:0] rsp_tdata;
   // div_by_zero
   logic [0:0]    rsp_tuser;

   cplx_result_type expected_results[$];
   int           mismatch_count = 0;
   int           surplus_count = 0;
   bit           stall_enable = 1'b1;

   complex_integer_alu uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mostly short gaps, sometimes a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // exact complex arithmetic, quotient truncated toward zero per part
   function automatic cplx_result_type complex_compute(logic [1:0] op,
         logic signed [OW-1:0] ar, logic signed [OW-1:0] ai,
         logic signed [OW-1:0] br, logic signed [OW-1:0] bi);
      cplx_result_type r;
      longint xr, xi, yr, yi, den, nre, nim;
      xr = ar; xi = ai; yr = br; yi = bi;
      r.dz = 1'b0;
      r.re = '0;
      r.im = '0;
      case (op)
         OP_ADD: begin
            r.re = RES_WIDTH'(xr + yr);
            r.im = RES_WIDTH'(xi + yi);
         end
         OP_SUB: begin
            r.re = RES_WIDTH'(xr - yr);
            r.im = RES_WIDTH'(xi - yi);
         end
         OP_MUL: begin
            r.re = RES_WIDTH'(xr*yr - xi*yi);
            r.im = RES_WIDTH'(xr*yi + xi*yr);
         end
         default: begin
            den = yr*yr + yi*yi;
            if (den == 0) begin
               r.dz = 1'b1;
            end else begin
               // sv division of longints truncates toward zero
               nre = xr*yr + xi*yi;
               nim = xi*yr - xr*yi;
               r.re = RES_WIDTH'(nre / den);
               r.im = RES_WIDTH'(nim / den);
            end
         end
      endcase
      return r;
   endfunction

   // one item, held until accepted, then a random gap
   task automatic send_operation(logic [1:0] op, logic [OW-1:0] ar, logic [OW-1:0] ai,
         logic [OW-1:0] br, logic [OW-1:0] bi);
      int g;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= DW'({bi, br, ai, ar});
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(complex_compute(op, ar, ai, br, bi));
      g = gap_length();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   function automatic logic [OW-1:0] random_operand();
      case ($urandom_range(0, 5))
         0: return {1'b0, {(OW-1){1'b1}}};
         1: return {1'b1, {(OW-1){1'b0}}};
         2: return OW'($urandom_range(0, 6)) - OW'(3);
         default: return OW'($urandom);
      endcase
   endfunction

   // extremes, every operation and the zero divisor
   task automatic test_directed();
      logic [OW-1:0] mx, mn;
      mx = {1'b0, {(OW-1){1'b1}}};
      mn = {1'b1, {(OW-1){1'b0}}};
      for (int op = 0; op < 4; op++) begin
         send_operation(op[1:0], mx, mx, mx, mx);
         send_operation(op[1:0], mn, mn, mn, mn);
         send_operation(op[1:0], mn, mx, mx, mn);
         send_operation(op[1:0], OW'(7), OW'(-7), OW'(2), '0);
      end
      send_operation(OP_DIV, OW'(5), OW'(-3), '0, '0);
      send_operation(OP_DIV, mn, mn, '0, '0);
      send_operation(OP_DIV, '0, '0, '0, '0);
      send_operation(OP_DIV, OW'(-7), OW'(7), OW'(2), OW'(3));
      send_operation(OP_DIV, OW'(1), OW'(1), mn, mn);
      send_operation(OP_MUL, mn, '0, mn, '0);
      drain_pipeline();
   endtask

   task automatic test_random(int count);
      logic [OW-1:0] br, bi;
      for (int i = 0; i < count; i++) begin
         br = random_operand();
         bi = random_operand();
         if ($urandom_range(0, 29) == 0) begin
            br = '0;
            bi = '0;
         end
         send_operation(2'($urandom), random_operand(), random_operand(), br, bi);
      end
   endtask

   // back-to-back with the result side always ready
   task automatic test_full_rate();
      stall_enable = 1'b0;
      for (int i = 0; i < 200; i++) begin
         req_tvalid <= 1'b1;
         req_tuser  <= 2'($urandom);
         req_tdata  <= DW'({$urandom, $urandom});
         do @(posedge clock); while (!req_tready);
         expected_results.push_back(complex_compute(req_tuser, req_tdata[OW-1:0],
            req_tdata[2*OW-1:OW], req_tdata[3*OW-1:2*OW], req_tdata[4*OW-1:3*OW]));
      end
      req_tvalid <= 1'b0;
      stall_enable = 1'b1;
   endtask

   // result side stalls at random
   always @(posedge clock) begin
      if (reset || !stall_enable)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= (gap_length() == 0);
   end

   // result checker
   always @(posedge clock) begin
      cplx_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            surplus_count++;
            $display("unexpected result item re=%h im=%h dz=%b",
               rsp_tdata[RES_WIDTH-1:0], rsp_tdata[2*RES_WIDTH-1:RES_WIDTH], rsp_tuser);
         end else begin
            e = expected_results.pop_front();
            if (rsp_tdata[RES_WIDTH-1:0] !== e.re ||
                rsp_tdata[2*RES_WIDTH-1:RES_WIDTH] !== e.im || rsp_tuser[0] !== e.dz) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected re=%h im=%h dz=%b, got re=%h im=%h dz=%b",
                     e.re, e.im, e.dz, rsp_tdata[RES_WIDTH-1:0],
                     rsp_tdata[2*RES_WIDTH-1:RES_WIDTH], rsp_tuser);
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(800);
      // hold off until the pipeline is empty
      drain_pipeline();
      test_full_rate();
      test_random(780);
      drain_pipeline();
      if (mismatch_count == 0 && surplus_count == 0 && expected_results.size() == 0)
         $display("tb_complex_integer_alu passed");
      else
         $display("tb_complex_integer_alu failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("tb_complex_integer_alu failed");
      $finish;
   end

endmodule

`default_nettype wire
